[hdl/aip_pkg.sv]
// ----------------------------------------------------------------------------
// aip_pkg: shared definitions of the ASCII integer parser
// Field widths, character and base codes, the parse phase type and the
// control bundle that the phase logic hands to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aip_pkg;

  // Fixed field widths of the transactions.
  localparam int BASE_BITS     = 6;
  localparam int CHAR_BITS     = 8;
  localparam int VALUE_BITS    = 64;
  localparam int CONSUMED_BITS = 16;

  // Defaults for the top-level parameters.
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  // Characters that steer the parse.
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_BITS-1:0] CH_X_LO  = 8'h78;  // 'x'
  localparam logic [CHAR_BITS-1:0] CH_X_UP  = 8'h58;  // 'X'
  localparam logic [CHAR_BITS-1:0] CH_A_LO  = 8'h61;  // 'a'
  localparam logic [CHAR_BITS-1:0] CH_F_LO  = 8'h66;  // 'f'
  localparam logic [CHAR_BITS-1:0] CH_A_UP  = 8'h41;  // 'A'
  localparam logic [CHAR_BITS-1:0] CH_F_UP  = 8'h46;  // 'F'

  // Base codes.
  localparam logic [BASE_BITS-1:0] BASE_DETECT = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT    = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC    = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX    = 6'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_ZERO,
    PH_X,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_MAC,
    ACC_LOAD
  } acc_op_t;

  typedef struct packed {
    logic    clear;    // start byte: accumulator and count begin from zero
    logic    minus;    // a leading minus was taken
    acc_op_t acc_op;
    logic [1:0] cnt_inc;
    logic    emit;     // this byte ends the number
    logic    any;      // at least one digit belongs to the number
  } step_ctl_t;

endpackage

[hdl/aip_in_if.sv]
// ----------------------------------------------------------------------------
// aip_in_if: character channel of the ASCII integer parser
// Valid/ready channel that carries one text byte and its framing flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aip_in_if import aip_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 start_req;
  logic [BASE_BITS-1:0] base_sel;
  logic [CHAR_BITS-1:0] char_byte;
  logic                 final_req;

  modport source (output valid, output start_req, output base_sel,
                  output char_byte, output final_req, input ready);
  modport sink   (input valid, input start_req, input base_sel,
                  input char_byte, input final_req, output ready);
endinterface

[hdl/aip_out_if.sv]
// ----------------------------------------------------------------------------
// aip_out_if: result channel of the ASCII integer parser
// Valid/ready channel that carries one parsed value and its byte count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface aip_out_if import aip_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VALUE_BITS-1:0]    value;
  logic [CONSUMED_BITS-1:0] consumed;

  modport source (output valid, output value, output consumed, input ready);
  modport sink   (input valid, input value, input consumed, output ready);
endinterface

[hdl/aip_ctrl.sv]
// ----------------------------------------------------------------------------
// aip_ctrl: parse phase logic
// Classifies the current byte against the parse phase and base, and
// produces the next phase, the next base and the datapath controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aip_ctrl import aip_pkg::*; (
  input  phase_t               phase_r,
  input  logic [BASE_BITS-1:0] base_r,
  input  logic                 signed_mode,
  input  logic                 start_req,
  input  logic [BASE_BITS-1:0] base_sel,
  input  logic [CHAR_BITS-1:0] char_byte,
  input  logic                 final_req,
  output phase_t               phase_nxt,
  output logic [BASE_BITS-1:0] base_nxt,
  output logic [3:0]           hex_val,
  output step_ctl_t            ctl
);

  // Bases that allow a 0x prefix.
  function automatic logic base_flex(input logic [BASE_BITS-1:0] b);
    return (b == BASE_DETECT) || (b == BASE_HEX);
  endfunction

  logic                 hex_ok;
  logic [BASE_BITS-1:0] base_in;
  logic [BASE_BITS-1:0] base_dig;
  logic                 minus_take;
  logic                 is_x;
  logic                 lead_path;
  logic                 lead_zero;
  logic                 dig_path;
  logic                 digit_ok;
  logic                 x_take;
  logic                 x_reject;
  logic                 any_dig;
  logic                 step_emit;
  logic                 final_emit;
  phase_t               phase_mid;

  // Hex character decode.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
      hex_val = 4'(char_byte - CH_ZERO);
    end else if (char_byte >= CH_A_LO && char_byte <= CH_F_LO) begin
      hex_val = 4'(char_byte - CH_A_LO + 8'd10);
    end else if (char_byte >= CH_A_UP && char_byte <= CH_F_UP) begin
      hex_val = 4'(char_byte - CH_A_UP + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Byte classification.
  always_comb begin
    base_in    = start_req ? base_sel : base_r;
    minus_take = start_req && signed_mode && (char_byte == CH_MINUS);
    is_x       = (char_byte == CH_X_LO) || (char_byte == CH_X_UP);
    lead_path  = (start_req && !minus_take) ||
                 (!start_req && (phase_r == PH_LEAD) && base_flex(base_r));
    lead_zero  = lead_path && base_flex(base_in) && (char_byte == CH_ZERO);
    dig_path   = (lead_path && !lead_zero) ||
                 (!start_req && (((phase_r == PH_LEAD) && !base_flex(base_r)) ||
                                 ((phase_r == PH_ZERO) && !is_x) ||
                                 (phase_r == PH_DIGITS)));
    base_dig = base_in;
    if (lead_path && (base_in == BASE_DETECT)) begin
      base_dig = BASE_DEC;
    end else if (!start_req && (phase_r == PH_ZERO) && (base_r == BASE_DETECT)) begin
      base_dig = BASE_OCT;
    end
    digit_ok  = hex_ok && (BASE_BITS'(hex_val) < base_dig);
    x_take    = !start_req && (phase_r == PH_X) && hex_ok;
    x_reject  = !start_req && (phase_r == PH_X) && !hex_ok;
    any_dig   = !start_req && ((phase_r == PH_ZERO) || (phase_r == PH_DIGITS));
    step_emit = (dig_path && !digit_ok) || x_reject;

    if (start_req) begin
      if (minus_take) begin
        phase_mid = PH_LEAD;
      end else if (lead_zero) begin
        phase_mid = PH_ZERO;
      end else begin
        phase_mid = digit_ok ? PH_DIGITS : PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE:   phase_mid = PH_IDLE;
        PH_LEAD: begin
          if (lead_zero) begin
            phase_mid = PH_ZERO;
          end else begin
            phase_mid = digit_ok ? PH_DIGITS : PH_IDLE;
          end
        end
        PH_ZERO: begin
          if (is_x) begin
            phase_mid = PH_X;
          end else begin
            phase_mid = digit_ok ? PH_DIGITS : PH_IDLE;
          end
        end
        PH_X:      phase_mid = hex_ok ? PH_DIGITS : PH_IDLE;
        PH_DIGITS: phase_mid = digit_ok ? PH_DIGITS : PH_IDLE;
        default:   phase_mid = PH_IDLE;
      endcase
    end

    final_emit = !step_emit && final_req && (phase_mid != PH_IDLE);
  end

  // Next state.
  always_comb begin
    phase_nxt = final_emit ? PH_IDLE : phase_mid;
    if (x_take || x_reject) begin
      base_nxt = BASE_HEX;
    end else if (dig_path) begin
      base_nxt = base_dig;
    end else begin
      base_nxt = base_in;
    end
  end

  // Datapath controls.
  always_comb begin
    ctl.clear = start_req;
    ctl.minus = minus_take;
    ctl.emit  = step_emit || final_emit;
    ctl.any   = step_emit ? (x_reject || any_dig) : (phase_mid != PH_LEAD);
    if (dig_path && digit_ok) begin
      ctl.acc_op = ACC_MAC;
    end else if (x_take) begin
      ctl.acc_op = ACC_LOAD;
    end else begin
      ctl.acc_op = ACC_HOLD;
    end
    if (x_take) begin
      ctl.cnt_inc = 2'd2;
    end else if (minus_take || lead_zero || (dig_path && digit_ok)) begin
      ctl.cnt_inc = 2'd1;
    end else begin
      ctl.cnt_inc = 2'd0;
    end
  end

endmodule

[hdl/aip_dpath.sv]
// ----------------------------------------------------------------------------
// aip_dpath: accumulator and byte count datapath
// One multiply-add per digit, a saturating byte count, and the sign and
// zero handling of the finished number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aip_dpath import aip_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  step_ctl_t                ctl,
  input  logic [VALUE_WIDTH-1:0]   acc_r,
  input  logic [COUNT_WIDTH-1:0]   cnt_r,
  input  logic                     neg_r,
  input  logic [BASE_BITS-1:0]     base_nxt,
  input  logic [3:0]               hex_val,
  output logic [VALUE_WIDTH-1:0]   acc_nxt,
  output logic [COUNT_WIDTH-1:0]   cnt_nxt,
  output logic                     neg_nxt,
  output logic [VALUE_BITS-1:0]    res_value,
  output logic [CONSUMED_BITS-1:0] res_consumed
);

  localparam int CNT_EXT = (COUNT_WIDTH > CONSUMED_BITS) ? COUNT_WIDTH : CONSUMED_BITS;

  logic [VALUE_WIDTH-1:0] acc_eff;
  logic [COUNT_WIDTH-1:0] cnt_eff;
  logic [VALUE_WIDTH-1:0] mac;
  logic [COUNT_WIDTH:0]   cnt_sum;
  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] signed_val;
  logic [COUNT_WIDTH-1:0] cnt_out;
  logic [CNT_EXT-1:0]     cnt_ext;

  assign acc_eff = ctl.clear ? '0 : acc_r;
  assign cnt_eff = ctl.clear ? '0 : cnt_r;
  assign neg_nxt = ctl.clear ? ctl.minus : neg_r;

  // The product is taken modulo 2^VALUE_WIDTH, as the accumulator wraps.
  assign mac = acc_eff * VALUE_WIDTH'(base_nxt) + VALUE_WIDTH'(hex_val);

  always_comb begin
    case (ctl.acc_op)
      ACC_MAC:  acc_nxt = mac;
      ACC_LOAD: acc_nxt = VALUE_WIDTH'(hex_val);
      default:  acc_nxt = acc_eff;
    endcase
  end

  assign cnt_sum = {1'b0, cnt_eff} + (COUNT_WIDTH + 1)'(ctl.cnt_inc);
  assign cnt_nxt = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];

  // A number without digits reports zero for both fields.
  assign mag        = ctl.any ? acc_nxt : '0;
  assign signed_val = neg_nxt ? ('0 - mag) : mag;
  assign cnt_out    = ctl.any ? cnt_nxt : '0;
  assign cnt_ext    = CNT_EXT'(cnt_out);

  assign res_value    = VALUE_BITS'(signed_val);
  assign res_consumed = cnt_ext[CONSUMED_BITS-1:0];

endmodule

[hdl/aip_obuf.sv]
// ----------------------------------------------------------------------------
// aip_obuf: result register
// Holds one finished result until the sink takes it and reports whether a
// new result can be loaded in this cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aip_obuf import aip_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic [VALUE_BITS-1:0]    value,
  input  logic [CONSUMED_BITS-1:0] consumed,
  output logic                     space,
  aip_out_if.source                out_bus
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic [VALUE_BITS-1:0]    value_r;
  logic [CONSUMED_BITS-1:0] consumed_r;

  assign space = !valid_r || out_bus.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r    <= value;
      consumed_r <= consumed;
    end
  end

  assign out_bus.valid    = valid_r;
  assign out_bus.value    = value_r;
  assign out_bus.consumed = consumed_r;

endmodule

[hdl/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_integer_parser: byte-serial string to integer converter
// Takes the text of a number one character per transaction and returns its
// value and the number of bytes that formed it, in the manner of strtoul and
// strtol. A transaction with start_req opens a number and carries its base;
// base 0 picks 16 for a "0x"/"0X" prefix followed by a hex digit, 8 for any
// other leading zero and 10 otherwise, and base 16 skips an optional prefix.
// With signed_mode set, a leading '-' negates the result. The first byte that
// is not a digit of the base ends the number and is dropped; a byte with
// final_req ends it after that byte is used. Either way exactly one result
// transaction follows. The value wraps modulo 2^VALUE_WIDTH and the count
// saturates at 2^COUNT_WIDTH - 1. The block takes one character per clock
// cycle while the result register has room; a character is registered on
// acceptance and its result, if any, is loaded into the result register
// when that character is processed. The pace is set only by the result
// register: while it holds a result that the sink has not taken, the
// character stage waits. Bytes that arrive without start_req while no number
// is open are dropped, and start_req in the middle of a number abandons it
// without a result. Write signed_mode only while no number is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_integer_parser import aip_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  aip_in_if.sink    in_bus,
  aip_out_if.source out_bus
);

  // Configuration register.
  logic signed_mode_r;

  // Character stage: the accepted transaction waits here until it is processed.
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 s1_start_r;
  logic [BASE_BITS-1:0] s1_base_r;
  logic [CHAR_BITS-1:0] s1_char_r;
  logic                 s1_final_r;

  // Parse state of the open number.
  phase_t                 phase_r;
  logic [BASE_BITS-1:0]   base_r;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic                   neg_r;

  phase_t                   phase_nxt;
  logic [BASE_BITS-1:0]     base_nxt;
  logic [VALUE_WIDTH-1:0]   acc_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_nxt;
  logic                     neg_nxt;
  logic [3:0]               hex_val;
  step_ctl_t                ctl;
  logic [VALUE_BITS-1:0]    res_value;
  logic [CONSUMED_BITS-1:0] res_consumed;
  logic                     obuf_space;
  logic                     advance;
  logic                     res_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  // The held character is processed whenever the result register can take
  // whatever it may produce. A new character enters in the same cycle.
  assign advance      = s1_valid_r && obuf_space;
  assign in_bus.ready = !s1_valid_r || advance;
  assign res_load     = advance && ctl.emit;

  always_comb begin
    if (in_bus.valid && in_bus.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_start_r <= in_bus.start_req;
      s1_base_r  <= in_bus.base_sel;
      s1_char_r  <= in_bus.char_byte;
      s1_final_r <= in_bus.final_req;
    end
  end

  aip_ctrl u_ctrl (
    .phase_r     (phase_r),
    .base_r      (base_r),
    .signed_mode (signed_mode_r),
    .start_req   (s1_start_r),
    .base_sel    (s1_base_r),
    .char_byte   (s1_char_r),
    .final_req   (s1_final_r),
    .phase_nxt   (phase_nxt),
    .base_nxt    (base_nxt),
    .hex_val     (hex_val),
    .ctl         (ctl)
  );

  aip_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .ctl          (ctl),
    .acc_r        (acc_r),
    .cnt_r        (cnt_r),
    .neg_r        (neg_r),
    .base_nxt     (base_nxt),
    .hex_val      (hex_val),
    .acc_nxt      (acc_nxt),
    .cnt_nxt      (cnt_nxt),
    .neg_nxt      (neg_nxt),
    .res_value    (res_value),
    .res_consumed (res_consumed)
  );

  // The parse state moves only when the held character is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      base_r  <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      neg_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      neg_r   <= neg_nxt;
    end
  end

  aip_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .value    (res_value),
    .consumed (res_consumed),
    .space    (obuf_space),
    .out_bus  (out_bus)
  );

`ifndef ASSERT_OFF
  // A result is never loaded over one that the sink has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_bus.valid || out_bus.ready))
    else $error("result register overwritten before it was taken");

  // Once a number has been reported, no number stays open.
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (phase_r == PH_IDLE))
    else $error("parse phase not idle after a result");

  // A result only appears after a character was processed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(res_load))
    else $error("result appeared without a processed character");

  // The character stage never drops a held transaction.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_char_r)))
    else $error("held character lost while stalled");
`endif

endmodule
